@@ sv/rpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rpd_pkg
// shared types and constants of the row pixel count peak detector
// ----------------------------------------------------------------------------
package rpd_pkg;

    // default sizes
    localparam int MAX_DIM_DEF     = 4096;
    localparam int HALF_WINDOW_DEF = 5;

    // field widths
    localparam int RED_W      = 8;
    localparam int SCORE_W    = 8;
    localparam int ROW_W      = 12;
    localparam int CUT_W      = 12;
    localparam int DIM_CFG_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // scoring
    localparam int HIT_STEP  = 3;
    localparam int SCORE_MAX = 255;

    // register reset values
    localparam int CUT_COLUMN_RST    = 400;
    localparam int RED_THRESHOLD_RST = 20;
    localparam int FRAME_COLS_RST    = 640;
    localparam int FRAME_ROWS_RST    = 480;

    // default weighted sum width
    localparam int DEF_GAIN  = HALF_WINDOW_DEF * (HALF_WINDOW_DEF + 1) / 2;
    localparam int DEF_SUM_W = $clog2(DEF_GAIN * SCORE_MAX + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CUT_COLUMN    = 2'd0,
        REG_RED_THRESHOLD = 2'd1,
        REG_FRAME_COLS    = 2'd2,
        REG_FRAME_ROWS    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [SCORE_W-1:0] row_score;
        logic               peak;
        logic               last;
    } result_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

@@ sv/rpd_cell.sv @@
// ----------------------------------------------------------------------------
// rpd_cell
// one row of score history with its weighted term on a running sum
// ----------------------------------------------------------------------------
module rpd_cell #(
    parameter int WEIGHT = 1,
    parameter int SUM_W  = rpd_pkg::DEF_SUM_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rpd_pkg::cell_ctl_t           ctl,
    input  logic [rpd_pkg::SCORE_W-1:0]  din,
    output logic [rpd_pkg::SCORE_W-1:0]  score,
    input  logic [SUM_W-1:0]             sum_in,
    output logic [SUM_W-1:0]             sum_out
);

    logic [rpd_pkg::SCORE_W-1:0] score_reg;
    logic [rpd_pkg::SCORE_W-1:0] score_next;
    logic [SUM_W-1:0]            term;

    always_comb
    begin
        score_next = score_reg;
        if (ctl.shift)
        begin
            score_next = din;
        end
        else if (ctl.clear)
        begin
            score_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
        end
        else
        begin
            score_reg <= score_next;
        end
    end

    // constant weight, small multiply
    assign term    = SUM_W'(score_reg) * SUM_W'(WEIGHT);
    assign sum_out = sum_in + term;
    assign score   = score_reg;

endmodule

@@ sv/rpd_drain.sv @@
// ----------------------------------------------------------------------------
// rpd_drain
// result slots loaded in parallel, drained one per cycle into the output register unless stalled
// ----------------------------------------------------------------------------
module rpd_drain #(
    parameter int SLOTS = rpd_pkg::HALF_WINDOW_DEF + 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [SLOTS-1:0]                 load_mask,
    input  rpd_pkg::result_t [SLOTS-1:0]     load_item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output rpd_pkg::result_t                 result,
    output logic                             busy
);

    localparam int RES_W = $bits(rpd_pkg::result_t);

    rpd_pkg::result_t [SLOTS-1:0] slot_reg;
    rpd_pkg::result_t [SLOTS-1:0] slot_next;
    logic [SLOTS-1:0]             slot_valid_reg;
    logic [SLOTS-1:0]             slot_valid_next;
    rpd_pkg::result_t             out_reg;
    rpd_pkg::result_t             out_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_free;
    logic                         move;

    assign out_free = !out_valid_reg || !result_stall;
    assign move     = out_free && slot_valid_reg[0];

    always_comb
    begin
        slot_next       = slot_reg;
        slot_valid_next = slot_valid_reg;
        if (load)
        begin
            slot_next       = load_item;
            slot_valid_next = load_mask;
        end
        else if (move)
        begin
            slot_next       = slot_reg >> RES_W;
            slot_valid_next = slot_valid_reg >> 1;
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_next       = slot_reg[0];
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign busy         = |slot_valid_reg;

endmodule

@@ sv/row_pixel_count_peak_detector_unit.sv @@
// ----------------------------------------------------------------------------
// row_pixel_count_peak_detector_unit: row hit scores with weighted peak test
// a row result passes the event register, a result slot and the output register; a frame end
// adds HALF_WINDOW more results at one per cycle unless stalled; throughput: one pixel per cycle
// unless stalled: a row-ending pixel stalls while the previous row end is in flight or results
// wait in the slots, so no new row end is taken until the last row's results have left the slots
// async reset clears counters, score history and registers to defaults (400, 20, 640, 480)
// ----------------------------------------------------------------------------
module row_pixel_count_peak_detector_unit #(
    parameter int MAX_DIM     = rpd_pkg::MAX_DIM_DEF,
    parameter int HALF_WINDOW = rpd_pkg::HALF_WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // pixel channel
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [rpd_pkg::RED_W-1:0]         pixel_red,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [rpd_pkg::ROW_W-1:0]         row_index,
    output logic [rpd_pkg::SCORE_W-1:0]       row_score,
    output logic                              peak,
    output logic                              last,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int DEPTH = 2 * HALF_WINDOW + 1;
    localparam int SLOTS = HALF_WINDOW + 1;
    localparam int GAIN  = HALF_WINDOW * (HALF_WINDOW + 1) / 2;
    localparam int SUM_W = $clog2(GAIN * rpd_pkg::SCORE_MAX + 1);
    localparam int SW    = rpd_pkg::SCORE_W;
    localparam int RW    = rpd_pkg::ROW_W;
    localparam int CW    = rpd_pkg::CUT_W;
    localparam int TW    = rpd_pkg::RED_W;
    localparam int FW    = rpd_pkg::DIM_CFG_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0] cut_column_reg, cut_column_next;
    logic [TW-1:0] red_threshold_reg, red_threshold_next;
    logic [FW-1:0] frame_cols_reg, frame_cols_next;
    logic [FW-1:0] frame_rows_reg, frame_rows_next;
    logic          cfg_write;

    // writes are to come only while idle; the block does not enforce it, and the port never pushes back
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        cut_column_next    = cut_column_reg;
        red_threshold_next = red_threshold_reg;
        frame_cols_next    = frame_cols_reg;
        frame_rows_next    = frame_rows_reg;
        if (cfg_write)
        begin
            case (rpd_pkg::cfg_reg_t'(cfg_index))
                rpd_pkg::REG_CUT_COLUMN:    cut_column_next    = cfg_data[CW-1:0];
                rpd_pkg::REG_RED_THRESHOLD: red_threshold_next = cfg_data[TW-1:0];
                rpd_pkg::REG_FRAME_COLS:    frame_cols_next    = cfg_data[FW-1:0];
                rpd_pkg::REG_FRAME_ROWS:    frame_rows_next    = cfg_data[FW-1:0];
                default:                    cut_column_next    = cut_column_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_column_reg    <= CW'(rpd_pkg::CUT_COLUMN_RST);
            red_threshold_reg <= TW'(rpd_pkg::RED_THRESHOLD_RST);
            frame_cols_reg    <= FW'(rpd_pkg::FRAME_COLS_RST);
            frame_rows_reg    <= FW'(rpd_pkg::FRAME_ROWS_RST);
        end
        else
        begin
            cut_column_reg    <= cut_column_next;
            red_threshold_reg <= red_threshold_next;
            frame_cols_reg    <= frame_cols_next;
            frame_rows_reg    <= frame_rows_next;
        end
    end

    // ------------------------------------------------------------------
    // frame size, clamped into the legal range
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] cols_eff;
    logic [DIM_W-1:0] rows_eff;

    always_comb
    begin
        if (frame_cols_reg == '0)
        begin
            cols_eff = DIM_W'(1);
        end
        else if (32'(frame_cols_reg) > 32'(MAX_DIM))
        begin
            cols_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            cols_eff = DIM_W'(frame_cols_reg);
        end
    end

    always_comb
    begin
        if (32'(frame_rows_reg) < 32'(HALF_WINDOW + 1))
        begin
            rows_eff = DIM_W'(HALF_WINDOW + 1);
        end
        else if (32'(frame_rows_reg) > 32'(MAX_DIM))
        begin
            rows_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            rows_eff = DIM_W'(frame_rows_reg);
        end
    end

    // ------------------------------------------------------------------
    // pixel stage: hit test, row accumulator, raster counters
    // ------------------------------------------------------------------
    logic [SW-1:0]    acc_reg, acc_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [SW:0]      acc_sum;
    logic [SW-1:0]    acc_hit;
    logic             hit;
    logic             row_end_now;
    logic             frame_end_now;
    logic             pixel_take;

    // row event register, read by the result stage in the cycle after the row end
    logic             evt_valid_reg, evt_valid_next;
    logic             evt_frame_reg, evt_frame_next;
    logic             evt_emit_reg, evt_emit_next;
    logic             evt_peak_ok_reg, evt_peak_ok_next;
    logic [DIM_W-1:0] evt_row_reg, evt_row_next;

    logic             drain_busy;

    assign hit = (32'(col_reg) <= 32'(cut_column_reg)) && (pixel_red > red_threshold_reg);

    // saturating add of one hit step
    assign acc_sum = {1'b0, acc_reg} + (SW + 1)'(rpd_pkg::HIT_STEP);
    always_comb
    begin
        acc_hit = acc_reg;
        if (hit)
        begin
            if (acc_sum > (SW + 1)'(rpd_pkg::SCORE_MAX))
            begin
                acc_hit = SW'(rpd_pkg::SCORE_MAX);
            end
            else
            begin
                acc_hit = acc_sum[SW-1:0];
            end
        end
    end

    assign row_end_now   = 32'(col_reg) >= (32'(cols_eff) - 32'd1);
    assign frame_end_now = 32'(row_reg) >= (32'(rows_eff) - 32'd1);

    // a row-ending pixel needs empty result slots and no event in flight
    assign pixel_stall = row_end_now && (evt_valid_reg || drain_busy);
    assign pixel_take  = pixel_valid && !pixel_stall;

    always_comb
    begin
        acc_next         = acc_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        evt_valid_next   = 1'b0;
        evt_frame_next   = evt_frame_reg;
        evt_emit_next    = evt_emit_reg;
        evt_peak_ok_next = evt_peak_ok_reg;
        evt_row_next     = evt_row_reg;
        if (pixel_take)
        begin
            if (row_end_now)
            begin
                acc_next       = '0;
                col_next       = '0;
                evt_valid_next = 1'b1;
                evt_row_next   = row_reg;
                evt_frame_next = frame_end_now;
                // a row result exists once the window has filled
                evt_emit_next  = (32'(row_reg) >= 32'(HALF_WINDOW)) || frame_end_now;
                // peak test only with full windows on both sides
                evt_peak_ok_next = (32'(row_reg) > 32'(2 * HALF_WINDOW))
                                && (32'(row_reg) < 32'(rows_eff));
                if (frame_end_now)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + DIM_W'(1);
                end
            end
            else
            begin
                acc_next = acc_hit;
                col_next = col_reg + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            evt_valid_reg   <= 1'b0;
            evt_frame_reg   <= 1'b0;
            evt_emit_reg    <= 1'b0;
            evt_peak_ok_reg <= 1'b0;
        end
        else
        begin
            acc_reg         <= acc_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            evt_valid_reg   <= evt_valid_next;
            evt_frame_reg   <= evt_frame_next;
            evt_emit_reg    <= evt_emit_next;
            evt_peak_ok_reg <= evt_peak_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_row_reg <= evt_row_next;
    end

    // ------------------------------------------------------------------
    // score history: a chain of cells, newest row in cell 0
    // cells below the center sum the future side, cells above it the past
    // side, each side weighted heaviest next to the center
    // ------------------------------------------------------------------
    rpd_pkg::cell_ctl_t cell_ctl;
    logic [SW-1:0]      score_w  [DEPTH];
    logic [SUM_W-1:0]   sum_in_w [DEPTH];
    logic [SUM_W-1:0]   sum_out_w[DEPTH];

    // shift on every accepted row end, clear as a frame's results are loaded into the slots
    assign cell_ctl.shift = pixel_take && row_end_now;
    assign cell_ctl.clear = evt_valid_reg && evt_frame_reg;

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        localparam int WEIGHT = (j < HALF_WINDOW)  ? j + 1 :
                                (j == HALF_WINDOW) ? GAIN  : DEPTH - j;
        logic [SW-1:0] din_w;

        if (j == 0)
        begin : g_head
            assign din_w = acc_hit;
        end
        else
        begin : g_link
            assign din_w = score_w[j-1];
        end

        if (j == 0 || j == HALF_WINDOW || j == DEPTH - 1)
        begin : g_sum_start
            assign sum_in_w[j] = '0;
        end
        else if (j < HALF_WINDOW)
        begin : g_sum_future
            assign sum_in_w[j] = sum_out_w[j-1];
        end
        else
        begin : g_sum_past
            assign sum_in_w[j] = sum_out_w[j+1];
        end

        rpd_cell #(
            .WEIGHT (WEIGHT),
            .SUM_W  (SUM_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cell_ctl),
            .din     (din_w),
            .score   (score_w[j]),
            .sum_in  (sum_in_w[j]),
            .sum_out (sum_out_w[j])
        );
    end

    // ------------------------------------------------------------------
    // result stage: peak compare and slot load
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]             center_sum;
    logic [SUM_W-1:0]             future_sum;
    logic [SUM_W-1:0]             past_sum;
    logic                         is_peak;
    logic                         drain_load;
    logic [SLOTS-1:0]             load_mask;
    rpd_pkg::result_t [SLOTS-1:0] load_item;
    rpd_pkg::result_t             out_item;

    assign center_sum = sum_out_w[HALF_WINDOW];
    assign future_sum = sum_out_w[HALF_WINDOW-1];
    assign past_sum   = sum_out_w[HALF_WINDOW+1];
    assign is_peak    = evt_peak_ok_reg && (center_sum > past_sum) && (center_sum > future_sum);

    assign drain_load = evt_valid_reg && (evt_emit_reg || evt_frame_reg);
    assign load_mask  = evt_frame_reg ? {SLOTS{1'b1}} : SLOTS'(1);

    // slot 0: the row at the window center; the rest flush the newest rows
    always_comb
    begin
        load_item[0].row_index = RW'(32'(evt_row_reg) - 32'(HALF_WINDOW));
        load_item[0].row_score = score_w[HALF_WINDOW];
        load_item[0].peak      = is_peak;
        load_item[0].last      = 1'b0;
        for (int i = 1; i < SLOTS; i++)
        begin
            load_item[i].row_index = RW'(32'(evt_row_reg) - 32'(HALF_WINDOW - i));
            load_item[i].row_score = score_w[HALF_WINDOW-i];
            load_item[i].peak      = 1'b0;
            load_item[i].last      = (i == SLOTS - 1);
        end
    end

    rpd_drain #(
        .SLOTS (SLOTS)
    ) u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (drain_load),
        .load_mask    (load_mask),
        .load_item    (load_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (out_item),
        .busy         (drain_busy)
    );

    assign row_index = out_item.row_index;
    assign row_score = out_item.row_score;
    assign peak      = out_item.peak;
    assign last      = out_item.last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // slots are only loaded when the previous results have all moved on
    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        drain_load |-> !drain_busy)
        else $error("result slots loaded while still busy");

    // a history shift never meets the end-of-frame clear
    a_shift_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(cell_ctl.shift && cell_ctl.clear))
        else $error("history shift during frame clear");

    // a frame end always leaves flushed rows waiting in the slots
    a_frame_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid_reg && evt_frame_reg) |=> drain_busy)
        else $error("frame end produced no flush results");

    // the center cell of the history is empty right after a frame clear
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctl.clear |=> (score_w[HALF_WINDOW] == '0))
        else $error("history not cleared after frame end");
`endif

endmodule
